[hw/rtl/sfa_pkg.sv]
// ----------------------------------------------------------------------------
// Signed fraction adder package
// Shared port widths and result status codes of the fraction adder.
// ----------------------------------------------------------------------------
package sfa_pkg;

  // Width of the numerator and denominator ports.
  localparam int unsigned IN_W = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

endpackage

[hw/rtl/sfa_divider.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// Bit-serial unsigned divider that produces one quotient bit per cycle and
// serves every gcd step and every division of the fraction adder.
// ----------------------------------------------------------------------------
module sfa_divider #(
  parameter int unsigned DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW:0]   quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned NW = DW + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [NW-1:0] quot_q, quot_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvsr_q, dvsr_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem_q, quot_q[NW-1]};
  assign fits    = (rem_sh >= {1'b0, dvsr_q});
  assign rem_sub = rem_sh - {1'b0, dvsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    done_d = (cnt_q == CW'(1));
    if (start_i) begin
      cnt_d  = CW'(NW);
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      quot_d = {quot_q[NW-2:0], fits};
      rem_d  = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  // A new division must never be issued while one is still running.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("divider started while busy");

  a_start_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_o && cnt_q != '0)
    else $error("divider finished right after start");
`endif

endmodule

[hw/rtl/sfa_ctrl.sv]
// ----------------------------------------------------------------------------
// Fraction adder sequencer
// Runs both gcd loops, the scaling products, the signed add and the final
// reductions, issuing every division to the shared divider.
// ----------------------------------------------------------------------------
module sfa_ctrl #(
  parameter int unsigned WIDTH = 32,
  localparam int unsigned LW = (WIDTH < sfa_pkg::IN_W) ? WIDTH : sfa_pkg::IN_W,
  localparam int unsigned DW = 2 * LW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     neg_a_i,
  input  logic [sfa_pkg::IN_W-1:0] num_a_i,
  input  logic [sfa_pkg::IN_W-1:0] den_a_i,
  input  logic                     neg_b_i,
  input  logic [sfa_pkg::IN_W-1:0] num_b_i,
  input  logic [sfa_pkg::IN_W-1:0] den_b_i,
  output logic                     done_o,
  output logic                     neg_sum_o,
  output logic [sfa_pkg::IN_W-1:0] num_sum_o,
  output logic [sfa_pkg::IN_W-1:0] den_sum_o,
  output sfa_pkg::status_e         status_o,
  output logic                     div_start_o,
  output logic [DW:0]              div_dividend_o,
  output logic [DW-1:0]            div_divisor_o,
  input  logic                     div_done_i,
  input  logic [DW:0]              div_quot_i,
  input  logic [DW-1:0]            div_rem_i
);

  localparam int unsigned IW = sfa_pkg::IN_W;
  localparam logic [IW-1:0] LIM = IW'((64'd1 << LW) - 64'd1);

  typedef enum logic [18:0] {
    S_IDLE = 19'b0000000000000000001,
    S_G1   = 19'b0000000000000000010,
    S_G1W  = 19'b0000000000000000100,
    S_M1   = 19'b0000000000000001000,
    S_M1W  = 19'b0000000000000010000,
    S_M2   = 19'b0000000000000100000,
    S_M2W  = 19'b0000000000001000000,
    S_MUL1 = 19'b0000000000010000000,
    S_MUL2 = 19'b0000000000100000000,
    S_MUL3 = 19'b0000000001000000000,
    S_ADD  = 19'b0000000010000000000,
    S_RED  = 19'b0000000100000000000,
    S_REDW = 19'b0000001000000000000,
    S_G2   = 19'b0000010000000000000,
    S_G2W  = 19'b0000100000000000000,
    S_DEN  = 19'b0001000000000000000,
    S_DENW = 19'b0010000000000000000,
    S_NUM  = 19'b0100000000000000000,
    S_NUMW = 19'b1000000000000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  logic             sa_q, sa_d, sb_q, sb_d, sign_q, sign_d;
  logic [LW-1:0]    na_q, na_d, nb_q, nb_d, da_q, da_d, db_q, db_d;
  logic [LW-1:0]    m1_q, m1_d, m2_q, m2_d;
  logic [DW-1:0]    x_q, x_d, y_q, y_d;
  logic [DW-1:0]    lcm_q, lcm_d, s1_q, s1_d, s2_q, s2_d, den_q, den_d;
  logic [DW:0]      sum_q, sum_d;
  logic             neg_q, neg_d;
  logic [IW-1:0]    num_out_q, num_out_d, den_out_q, den_out_d;
  sfa_pkg::status_e status_q, status_d;

  logic [LW-1:0] mul_a, mul_b;
  logic [DW-1:0] prod;
  logic          in_zero, in_wide;

  assign in_zero = (den_a_i == '0) || (den_b_i == '0);
  assign in_wide = (num_a_i > LIM) || (den_a_i > LIM) || (num_b_i > LIM) || (den_b_i > LIM);

  // One multiplier, shared by the three scaling products.
  always_comb begin
    unique case (state_q)
      S_MUL2: begin
        mul_a = na_q;
        mul_b = m2_q;
      end
      S_MUL3: begin
        mul_a = nb_q;
        mul_b = m1_q;
      end
      default: begin
        mul_a = m1_q;
        mul_b = db_q;
      end
    endcase
  end

  assign prod = DW'(mul_a) * DW'(mul_b);

  always_comb begin
    unique case (state_q)
      S_M1: begin
        div_dividend_o = (DW + 1)'(da_q);
        div_divisor_o  = x_q;
      end
      S_M2: begin
        div_dividend_o = (DW + 1)'(db_q);
        div_divisor_o  = x_q;
      end
      S_RED: begin
        div_dividend_o = sum_q;
        div_divisor_o  = lcm_q;
      end
      S_DEN: begin
        div_dividend_o = (DW + 1)'(lcm_q);
        div_divisor_o  = x_q;
      end
      S_NUM: begin
        div_dividend_o = sum_q;
        div_divisor_o  = x_q;
      end
      default: begin
        div_dividend_o = (DW + 1)'(x_q);
        div_divisor_o  = y_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    div_start_o = 1'b0;
    sa_d        = sa_q;
    sb_d        = sb_q;
    sign_d      = sign_q;
    na_d        = na_q;
    nb_d        = nb_q;
    da_d        = da_q;
    db_d        = db_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    x_d         = x_q;
    y_d         = y_q;
    lcm_d       = lcm_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    den_d       = den_q;
    sum_d       = sum_q;
    neg_d       = neg_q;
    num_out_d   = num_out_q;
    den_out_d   = den_out_q;
    status_d    = status_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (in_zero || in_wide) begin
            done_d    = 1'b1;
            neg_d     = 1'b0;
            num_out_d = '0;
            den_out_d = '0;
            status_d  = in_zero ? sfa_pkg::ST_ZERO_DEN : sfa_pkg::ST_OVERFLOW;
          end else begin
            sa_d    = neg_a_i;
            sb_d    = neg_b_i;
            na_d    = num_a_i[LW-1:0];
            nb_d    = num_b_i[LW-1:0];
            da_d    = den_a_i[LW-1:0];
            db_d    = den_b_i[LW-1:0];
            x_d     = DW'(den_a_i[LW-1:0]);
            y_d     = DW'(den_b_i[LW-1:0]);
            state_d = S_G1;
          end
        end
      end
      S_G1: begin
        if (y_q == '0) begin
          state_d = S_M1;
        end else begin
          div_start_o = 1'b1;
          state_d     = S_G1W;
        end
      end
      S_G1W: begin
        if (div_done_i) begin
          x_d     = y_q;
          y_d     = div_rem_i;
          state_d = S_G1;
        end
      end
      S_M1: begin
        div_start_o = 1'b1;
        state_d     = S_M1W;
      end
      S_M1W: begin
        if (div_done_i) begin
          m1_d    = div_quot_i[LW-1:0];
          state_d = S_M2;
        end
      end
      S_M2: begin
        div_start_o = 1'b1;
        state_d     = S_M2W;
      end
      S_M2W: begin
        if (div_done_i) begin
          m2_d    = div_quot_i[LW-1:0];
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        lcm_d   = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        s1_d    = prod;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        s2_d    = prod;
        state_d = S_ADD;
      end
      S_ADD: begin
        if (sa_q == sb_q) begin
          sum_d  = {1'b0, s1_q} + {1'b0, s2_q};
          sign_d = sa_q;
        end else if (s1_q >= s2_q) begin
          sum_d  = {1'b0, s1_q - s2_q};
          sign_d = sa_q;
        end else begin
          sum_d  = {1'b0, s2_q - s1_q};
          sign_d = sb_q;
        end
        state_d = S_RED;
      end
      S_RED: begin
        if (sum_q == '0) begin
          // A zero sum keeps the sign of the first operand.
          done_d    = 1'b1;
          neg_d     = sa_q;
          num_out_d = '0;
          den_out_d = IW'(1);
          status_d  = sfa_pkg::ST_OK;
          state_d   = S_IDLE;
        end else begin
          div_start_o = 1'b1;
          state_d     = S_REDW;
        end
      end
      S_REDW: begin
        if (div_done_i) begin
          x_d     = lcm_q;
          y_d     = div_rem_i;
          state_d = S_G2;
        end
      end
      S_G2: begin
        if (y_q == '0) begin
          state_d = S_DEN;
        end else begin
          div_start_o = 1'b1;
          state_d     = S_G2W;
        end
      end
      S_G2W: begin
        if (div_done_i) begin
          x_d     = y_q;
          y_d     = div_rem_i;
          state_d = S_G2;
        end
      end
      S_DEN: begin
        div_start_o = 1'b1;
        state_d     = S_DENW;
      end
      S_DENW: begin
        if (div_done_i) begin
          den_d   = div_quot_i[DW-1:0];
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        div_start_o = 1'b1;
        state_d     = S_NUMW;
      end
      S_NUMW: begin
        if (div_done_i) begin
          done_d = 1'b1;
          if ((div_quot_i[DW:LW] != '0) || (den_q[DW-1:LW] != '0)) begin
            neg_d     = 1'b0;
            num_out_d = '0;
            den_out_d = '0;
            status_d  = sfa_pkg::ST_OVERFLOW;
          end else begin
            neg_d     = sign_q;
            num_out_d = IW'(div_quot_i[LW-1:0]);
            den_out_d = IW'(den_q[LW-1:0]);
            status_d  = sfa_pkg::ST_OK;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q      <= sa_d;
    sb_q      <= sb_d;
    sign_q    <= sign_d;
    na_q      <= na_d;
    nb_q      <= nb_d;
    da_q      <= da_d;
    db_q      <= db_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    x_q       <= x_d;
    y_q       <= y_d;
    lcm_q     <= lcm_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    den_q     <= den_d;
    sum_q     <= sum_d;
    neg_q     <= neg_d;
    num_out_q <= num_out_d;
    den_out_q <= den_out_d;
    status_q  <= status_d;
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign neg_sum_o = neg_q;
  assign num_sum_o = num_out_q;
  assign den_sum_o = den_out_q;
  assign status_o  = status_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != sfa_pkg::ST_OK |->
      !neg_sum_o && num_sum_o == '0 && den_sum_o == '0)
    else $error("error result carries nonzero fields");

  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == sfa_pkg::ST_OK |-> den_sum_o != '0)
    else $error("valid result with zero denominator");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("sequencer left idle without a request");
`endif

endmodule

[hw/rtl/signed_fraction_adder.sv]
// ----------------------------------------------------------------------------
// Signed fraction adder
// Adds two sign-magnitude fractions and returns the sum in lowest terms.
// ----------------------------------------------------------------------------
// Channel   Ports                        Handshake
// request   start_i, busy_o, operands    taken when start_i is high, busy_o low
// result    done_o, sum fields, status   one-cycle strobe, cannot be held off
//
// Zero denominators and operands above the value limit 2**LW - 1, with
// LW = min(WIDTH, 32), give their result in the cycle after the request,
// with busy_o staying low. Otherwise the result follows the first gcd loop,
// the scale divisions, the products, the signed add and, unless the sum is
// zero, the reduction, second gcd loop and final divisions on the divider.
// Reset returns the sequencer and divider to idle.
// ----------------------------------------------------------------------------
module signed_fraction_adder #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     neg_a_i,
  input  logic [sfa_pkg::IN_W-1:0] num_a_i,
  input  logic [sfa_pkg::IN_W-1:0] den_a_i,
  input  logic                     neg_b_i,
  input  logic [sfa_pkg::IN_W-1:0] num_b_i,
  input  logic [sfa_pkg::IN_W-1:0] den_b_i,
  output logic                     done_o,
  output logic                     neg_sum_o,
  output logic [sfa_pkg::IN_W-1:0] num_sum_o,
  output logic [sfa_pkg::IN_W-1:0] den_sum_o,
  output logic [1:0]               status_o
);

  localparam int unsigned LW = (WIDTH < sfa_pkg::IN_W) ? WIDTH : sfa_pkg::IN_W;
  localparam int unsigned DW = 2 * LW;

  logic             div_start;
  logic [DW:0]      div_dividend;
  logic [DW-1:0]    div_divisor;
  logic             div_done;
  logic [DW:0]      div_quot;
  logic [DW-1:0]    div_rem;
  sfa_pkg::status_e status;

  sfa_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .neg_a_i        (neg_a_i),
    .num_a_i        (num_a_i),
    .den_a_i        (den_a_i),
    .neg_b_i        (neg_b_i),
    .num_b_i        (num_b_i),
    .den_b_i        (den_b_i),
    .done_o         (done_o),
    .neg_sum_o      (neg_sum_o),
    .num_sum_o      (num_sum_o),
    .den_sum_o      (den_sum_o),
    .status_o       (status),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .div_rem_i      (div_rem)
  );

  sfa_divider #(
    .DW(DW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign status_o = status;

endmodule

[tb/sv/signed_fraction_adder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signed fraction adder testbench
// Drives the adder with directed and random requests. A scoreboard predicts
// each reduced sum in exact arithmetic and checks every result strobe against
// the oldest outstanding request.
// ----------------------------------------------------------------------------
module signed_fraction_adder_tb;

  localparam int unsigned IN_W         = sfa_pkg::IN_W;
  localparam int unsigned WIDTH        = 32;
  localparam int unsigned N_RANDOM     = 1930;
  localparam int unsigned N_QUIET      = 200;
  localparam int unsigned DRAIN_CYCLES = 12000;
  localparam longint unsigned CYCLE_LIMIT = 64'd100_000_000;

  typedef struct packed {
    logic             neg;
    logic [IN_W-1:0]  num;
    logic [IN_W-1:0]  den;
    sfa_pkg::status_e status;
  } fraction_sum_t;

  class sum_scoreboard;
    fraction_sum_t sum_q[$];
    int unsigned   errors;
    int unsigned   n_requests;
    int unsigned   n_checked;
    int unsigned   n_zero_den;
    int unsigned   n_overflow;
    int unsigned   n_zero_sum;

    function logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function fraction_sum_t predict_sum(logic neg_a, logic [IN_W-1:0] num_a,
                                        logic [IN_W-1:0] den_a, logic neg_b,
                                        logic [IN_W-1:0] num_b,
                                        logic [IN_W-1:0] den_b);
      logic [63:0]   lim, g, m1, m2, lcm, s1, s2, rem, dv, den;
      logic [64:0]   total, quo;
      logic          sign;
      fraction_sum_t r;
      r = '0;
      r.status = sfa_pkg::ST_OK;
      lim = (WIDTH >= 32) ? 64'hFFFF_FFFF : ((64'd1 << WIDTH) - 64'd1);
      if (den_a == 0 || den_b == 0) begin
        r.status = sfa_pkg::ST_ZERO_DEN;
        return r;
      end
      if (num_a > lim || den_a > lim || num_b > lim || den_b > lim) begin
        r.status = sfa_pkg::ST_OVERFLOW;
        return r;
      end
      g   = common_divisor(64'(den_a), 64'(den_b));
      m1  = 64'(den_a) / g;
      m2  = 64'(den_b) / g;
      lcm = m1 * 64'(den_b);
      s1  = 64'(num_a) * m2;
      s2  = 64'(num_b) * m1;
      if (neg_a == neg_b) begin
        sign  = neg_a;
        total = {1'b0, s1} + {1'b0, s2};
      end else if (s1 >= s2) begin
        sign  = neg_a;
        total = {1'b0, s1 - s2};
      end else begin
        sign  = neg_b;
        total = {1'b0, s2 - s1};
      end
      if (total == 0) begin
        r.neg = neg_a;
        r.den = 1;
        return r;
      end
      rem = 64'(total % {1'b0, lcm});
      dv  = common_divisor(lcm, rem);
      den = lcm / dv;
      quo = total / {1'b0, dv};
      if (quo[64] || quo[63:0] > lim || den > lim) begin
        r.status = sfa_pkg::ST_OVERFLOW;
        return r;
      end
      r.neg = sign;
      r.num = quo[IN_W-1:0];
      r.den = den[IN_W-1:0];
      return r;
    endfunction

    function void note_request(logic neg_a, logic [IN_W-1:0] num_a,
                               logic [IN_W-1:0] den_a, logic neg_b,
                               logic [IN_W-1:0] num_b, logic [IN_W-1:0] den_b);
      sum_q.push_back(predict_sum(neg_a, num_a, den_a, neg_b, num_b, den_b));
      n_requests++;
    endfunction

    function void check_result(logic neg, logic [IN_W-1:0] num, logic [IN_W-1:0] den,
                               logic [1:0] status);
      fraction_sum_t exp_sum;
      if (sum_q.size() == 0) begin
        $display("%0t: result with no request outstanding: neg %0b num %h den %h status %0d",
                 $time, neg, num, den, status);
        errors++;
        return;
      end
      exp_sum = sum_q.pop_front();
      n_checked++;
      case (exp_sum.status)
        sfa_pkg::ST_ZERO_DEN: n_zero_den++;
        sfa_pkg::ST_OVERFLOW: n_overflow++;
        default: if (exp_sum.num == 0) n_zero_sum++;
      endcase
      if (status !== exp_sum.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_sum.status, status);
        errors++;
      end
      if (neg !== exp_sum.neg) begin
        $display("%0t: neg_sum mismatch: expected %0b, actual %0b", $time, exp_sum.neg, neg);
        errors++;
      end
      if (num !== exp_sum.num) begin
        $display("%0t: num_sum mismatch: expected %h, actual %h", $time, exp_sum.num, num);
        errors++;
      end
      if (den !== exp_sum.den) begin
        $display("%0t: den_sum mismatch: expected %h, actual %h", $time, exp_sum.den, den);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return sum_q.size();
    endfunction
  endclass

  logic            clk_i   = 1'b0;
  logic            rst_ni  = 1'b0;
  logic            start_i = 1'b0;
  logic            busy_o;
  logic            neg_a_i = 1'b0;
  logic [IN_W-1:0] num_a_i = '0;
  logic [IN_W-1:0] den_a_i = '0;
  logic            neg_b_i = 1'b0;
  logic [IN_W-1:0] num_b_i = '0;
  logic [IN_W-1:0] den_b_i = '0;
  logic            done_o;
  logic            neg_sum_o;
  logic [IN_W-1:0] num_sum_o;
  logic [IN_W-1:0] den_sum_o;
  logic [1:0]      status_o;

  sum_scoreboard   sb = new();
  bit              quiet_phase = 1'b0;
  longint unsigned cycle_count = 0;

  signed_fraction_adder #(
    .WIDTH(WIDTH)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .neg_a_i  (neg_a_i),
    .num_a_i  (num_a_i),
    .den_a_i  (den_a_i),
    .neg_b_i  (neg_b_i),
    .num_b_i  (num_b_i),
    .den_b_i  (den_b_i),
    .done_o   (done_o),
    .neg_sum_o(neg_sum_o),
    .num_sum_o(num_sum_o),
    .den_sum_o(den_sum_o),
    .status_o (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(neg_sum_o, num_sum_o, den_sum_o, status_o);
      end
      if (start_i && !busy_o) begin
        sb.note_request(neg_a_i, num_a_i, den_a_i, neg_b_i, num_b_i, den_b_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Small values keep the Euclid loops short; full-width values reach every bit.
  function automatic logic [IN_W-1:0] rand_mag(int unsigned cls);
    case (cls)
      0: return IN_W'($urandom_range(0, 255));
      1: return IN_W'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 15))
          0: return '1;
          1: return IN_W'(32'h8000_0000 >> $urandom_range(0, 31));
          default: return IN_W'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned rand_class();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r < 4) ? 0 : (r < 7) ? 1 : 2;
  endfunction

  task automatic send_request(input logic neg_a, input logic [IN_W-1:0] num_a,
                              input logic [IN_W-1:0] den_a, input logic neg_b,
                              input logic [IN_W-1:0] num_b, input logic [IN_W-1:0] den_b);
    if (!quiet_phase && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    neg_a_i <= neg_a;
    num_a_i <= num_a;
    den_a_i <= den_a;
    neg_b_i <= neg_b;
    num_b_i <= num_b;
    den_b_i <= den_b;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    logic            na_neg, nb_neg;
    logic [IN_W-1:0] na, da, nb, db;
    int unsigned     ca, cb, mode;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(1'b0, 1, 2, 1'b0, 1, 3);
    send_request(1'b1, 1, 2, 1'b0, 1, 3);
    send_request(1'b0, 1, 3, 1'b1, 1, 2);
    send_request(1'b1, 0, 5, 1'b0, 0, 7);
    send_request(1'b0, 3, 4, 1'b1, 3, 4);
    send_request(1'b1, 6, 8, 1'b0, 3, 4);
    send_request(1'b0, 5, 0, 1'b0, 1, 3);
    send_request(1'b1, 5, 7, 1'b1, 1, 0);
    send_request(1'b1, '1, 0, 1'b1, '1, 0);
    send_request(1'b0, '1, 1, 1'b0, '1, 1);
    send_request(1'b0, 1, '1, 1'b0, 1, 32'hFFFF_FFFE);
    send_request(1'b1, '1, '1, 1'b1, '1, 32'hFFFF_FFFE);
    send_request(1'b0, '1, '1, 1'b1, 0, 1);
    send_request(1'b1, '1, 1, 1'b0, 1, 1);
    send_request(1'b0, '1, 1, 1'b1, '1, 1);
    send_request(1'b0, 1, '1, 1'b1, 1, '1);
    send_request(1'b0, 7, 12, 1'b0, 5, 18);
    send_request(1'b1, 5, 10, 1'b1, 5, 10);
    send_request(1'b0, 1, 32'd2971215073, 1'b0, 1, 32'd1836311903);
    send_request(1'b0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1, 32'h4000_0000);
    send_request(1'b1, 0, 1, 1'b0, 0, 1);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      quiet_phase = (i >= N_RANDOM - N_QUIET);
      ca     = rand_class();
      cb     = rand_class();
      na_neg = $urandom_range(0, 1);
      nb_neg = $urandom_range(0, 1);
      na     = rand_mag(ca);
      da     = rand_mag(ca);
      nb     = rand_mag(cb);
      db     = rand_mag(cb);
      if (da == 0) da = 1;
      if (db == 0) db = 1;
      mode = $urandom_range(0, 19);
      case (mode)
        0: begin
          case ($urandom_range(0, 2))
            0: da = 0;
            1: db = 0;
            default: begin
              da = 0;
              db = 0;
            end
          endcase
        end
        1: begin
          nb     = na;
          db     = da;
          nb_neg = ~na_neg;
        end
        2: db = da;
        3: begin
          nb = na;
          db = da;
        end
        default: ;
      endcase
      send_request(na_neg, na, da, nb_neg, nb, db);
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d requests, %0d results checked in %0d cycles",
             sb.n_requests, sb.n_checked, cycle_count);
    $display("summary: %0d zero denominators, %0d overflows, %0d zero sums, %0d errors",
             sb.n_zero_den, sb.n_overflow, sb.n_zero_sum, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_divider.sv
hw/rtl/sfa_ctrl.sv
hw/rtl/signed_fraction_adder.sv
tb/sv/signed_fraction_adder_tb.sv
